@@ rtl/core/quaternion_small_angle_update_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the small-angle quaternion update
// Shared property shapes used by the port checker.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_SMALL_ANGLE_UPDATE_MACROS_SVH
`define QUATERNION_SMALL_ANGLE_UPDATE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define QSAU_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("%m: implication check failed");

// Next-cycle implication, disabled during reset.
`define QSAU_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("%m: next-cycle check failed");

`endif

@@ rtl/core/qsau_pkg.sv @@
// ----------------------------------------------------------------------------
// qsau_pkg
// Shared constants and types of the small-angle quaternion update.
// ----------------------------------------------------------------------------
`default_nettype none

package qsau_pkg;

  // One result bit per square-root stage and per divider stage.
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 32;

  // Register stages before the square root, and between root and divider.
  localparam int FRONT_STAGES = 7;
  localparam int MID_STAGES   = 1;
  localparam int TOTAL_STAGES = FRONT_STAGES + SQRT_STEPS + MID_STAGES + DIV_STEPS;

  localparam int MAG_W = 31;
  localparam int NUM_W = 62;

  typedef logic [MAG_W-1:0] mag_t;

  typedef struct packed {
    logic [3:0] sgn;
    logic       zero;
  } side_t;

  typedef struct packed {
    logic signed [31:0] w;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               zero;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/qsau_sqrt.sv @@
// ----------------------------------------------------------------------------
// qsau_sqrt
// Pipelined integer square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qsau_sqrt (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] val,
  output logic      [31:0] root
);

  localparam int N = qsau_pkg::SQRT_STEPS;

  logic [63:0] v_r   [N];
  logic [63:0] res_r [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [63:0] BIT = 64'(1) << (62 - 2 * k);
    logic [63:0] v_in;
    logic [63:0] res_in;
    logic [64:0] trial;
    logic [63:0] v_next;
    logic [63:0] res_next;

    if (k == 0) begin : g_first
      assign v_in   = val;
      assign res_in = '0;
    end else begin : g_rest
      assign v_in   = v_r[k-1];
      assign res_in = res_r[k-1];
    end

    always_comb begin
      trial = {1'b0, res_in} + {1'b0, BIT};
      if ({1'b0, v_in} >= trial) begin
        v_next   = v_in - trial[63:0];
        res_next = (res_in >> 1) + BIT;
      end else begin
        v_next   = v_in;
        res_next = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_r[k]   <= v_next;
        res_r[k] <= res_next;
      end
    end
  end

  assign root = res_r[N-1][31:0];

endmodule

`default_nettype wire

@@ rtl/core/qsau_div.sv @@
// ----------------------------------------------------------------------------
// qsau_div
// Pipelined restoring divider, 62-bit numerator by 32-bit divisor, one
// quotient bit per stage. The quotient must fit in 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module qsau_div (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [qsau_pkg::NUM_W-1:0]   num,
  input  wire logic [31:0]                  den,
  output logic      [31:0]                  quo
);

  localparam int N = qsau_pkg::DIV_STEPS;

  logic [31:0] rem_r [N];
  logic [31:0] q_r   [N];
  logic [31:0] lo_r  [N];
  logic [31:0] den_r [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [31:0] rem_in;
    logic [31:0] q_in;
    logic [31:0] lo_in;
    logic [31:0] den_in;
    logic [32:0] t;
    logic [31:0] rem_next;
    logic [31:0] q_next;

    if (k == 0) begin : g_first
      assign rem_in = 32'(num[qsau_pkg::NUM_W-1:32]);
      assign q_in   = '0;
      assign lo_in  = num[31:0];
      assign den_in = den;
    end else begin : g_rest
      assign rem_in = rem_r[k-1];
      assign q_in   = q_r[k-1];
      assign lo_in  = lo_r[k-1];
      assign den_in = den_r[k-1];
    end

    always_comb begin
      t      = {rem_in, lo_in[31-k]};
      q_next = q_in;
      if (t >= {1'b0, den_in}) begin
        rem_next       = 32'(t - {1'b0, den_in});
        q_next[31-k]   = 1'b1;
      end else begin
        rem_next       = t[31:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_next;
        q_r[k]   <= q_next;
        lo_r[k]  <= lo_in;
        den_r[k] <= den_in;
      end
    end
  end

  assign quo = q_r[N-1];

endmodule

`default_nettype wire

@@ rtl/core/quaternion_small_angle_update.sv @@
// ----------------------------------------------------------------------------
// quaternion_small_angle_update
// Small-angle quaternion update q * (1, r/2), normalized, in Q2.30.
// ----------------------------------------------------------------------------
// Usage: present quat_w..quat_z and rot_x..rot_z with in_valid; the item is
// taken at a rising edge where in_valid is high and in_stall is low. The
// result (out_w..out_z, zero_norm) is offered with out_valid and leaves at an
// edge where out_valid is high and out_stall is low.
// From the accepting edge to out_valid an item passes seven front
// stages (products, sums, magnitudes, bit length, block shift, squares,
// sum of squares), 32 square-root stages, one numerator stage and 32
// divider stages, each producing one bit.
// Throughput is one item per cycle while in_stall is low; fully pipelined.
// A two-entry output buffer takes finished items. The pipeline advances
// only while that buffer has a free entry, so in_stall depends only on
// registered state. When the receiver stalls, the buffer fills and the
// whole pipeline holds in place, losing and repeating nothing.
// Reset clears all valid bits and empties the output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_small_angle_update (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] quat_w,
  input  wire logic signed [31:0] quat_x,
  input  wire logic signed [31:0] quat_y,
  input  wire logic signed [31:0] quat_z,
  input  wire logic signed [31:0] rot_x,
  input  wire logic signed [31:0] rot_y,
  input  wire logic signed [31:0] rot_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_w,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic signed [31:0]      out_z,
  output logic                    zero_norm
);

  localparam int TOT   = qsau_pkg::TOTAL_STAGES;
  localparam int NSQ   = qsau_pkg::SQRT_STEPS;

  // Global advance: the whole pipeline moves while the output buffer has room.
  logic [1:0] cnt;
  logic       en;
  assign en       = (cnt != 2'd2);
  assign in_stall = !en;

  logic [TOT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOT-2:0], in_valid};
    end
  end

  // Stage 1: the twelve cross products, and the quaternion itself.
  logic signed [63:0] prod_r [12];
  logic signed [31:0] qv_r   [4];

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r[0]  <= quat_x * rot_x;
      prod_r[1]  <= quat_y * rot_y;
      prod_r[2]  <= quat_z * rot_z;
      prod_r[3]  <= quat_w * rot_x;
      prod_r[4]  <= quat_y * rot_z;
      prod_r[5]  <= quat_z * rot_y;
      prod_r[6]  <= quat_w * rot_y;
      prod_r[7]  <= quat_z * rot_x;
      prod_r[8]  <= quat_x * rot_z;
      prod_r[9]  <= quat_w * rot_z;
      prod_r[10] <= quat_x * rot_y;
      prod_r[11] <= quat_y * rot_x;
      qv_r[0]    <= quat_w;
      qv_r[1]    <= quat_x;
      qv_r[2]    <= quat_y;
      qv_r[3]    <= quat_z;
    end
  end

  // Stage 2: Hamilton product at scale 2^59; halving the cross terms floors.
  logic signed [63:0] p_r [4];

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= (64'(qv_r[0]) <<< 29) - (prod_r[0] >>> 2) - (prod_r[1] >>> 2)
                - (prod_r[2] >>> 2);
      p_r[1] <= (64'(qv_r[1]) <<< 29) + (prod_r[3] >>> 2) + (prod_r[4] >>> 2)
                - (prod_r[5] >>> 2);
      p_r[2] <= (64'(qv_r[2]) <<< 29) + (prod_r[6] >>> 2) + (prod_r[7] >>> 2)
                - (prod_r[8] >>> 2);
      p_r[3] <= (64'(qv_r[3]) <<< 29) + (prod_r[9] >>> 2) + (prod_r[10] >>> 2)
                - (prod_r[11] >>> 2);
    end
  end

  // Stage 3: magnitudes and signs. The output sign is the component's sign
  // relative to the scalar part, which folds in the negation for w < 0.
  logic [62:0]     mag3_r [4];
  qsau_pkg::side_t side_r [2:TOT-1];
  qsau_pkg::side_t side3;
  logic [62:0]     mag3 [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [63:0] a;
      a             = p_r[i][63] ? 64'(-p_r[i]) : 64'(p_r[i]);
      mag3[i]       = a[62:0];
      side3.sgn[i]  = p_r[i][63] ^ p_r[0][63];
    end
    side3.zero = (p_r[0] == '0) && (p_r[1] == '0) && (p_r[2] == '0) && (p_r[3] == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        mag3_r[i] <= mag3[i];
      end
    end
  end

  for (genvar k = 2; k < TOT; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        if (k == 2) begin
          side_r[k] <= side3;
        end else begin
          side_r[k] <= side_r[k-1];
        end
      end
    end
  end

  // Stage 4: bit length of the largest magnitude, from the OR of all four.
  logic [62:0] mag4_r [4];
  logic [6:0]  bl4_r;
  logic [62:0] or3;
  logic [6:0]  bl3;

  always_comb begin
    or3 = mag3_r[0] | mag3_r[1] | mag3_r[2] | mag3_r[3];
    bl3 = '0;
    for (int b = 0; b < 63; b++) begin
      if (or3[b]) begin
        bl3 = 7'(b + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag4_r <= mag3_r;
      bl4_r  <= bl3;
    end
  end

  // Stage 5: block scaling so the largest magnitude lies in [2^30, 2^31).
  qsau_pkg::mag_t mag5_r [4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        if (bl4_r > 7'd31) begin
          mag5_r[i] <= qsau_pkg::MAG_W'(mag4_r[i] >> (bl4_r - 7'd31));
        end else begin
          mag5_r[i] <= qsau_pkg::MAG_W'(mag4_r[i] << (7'd31 - bl4_r));
        end
      end
    end
  end

  // Stage 6: squares. Stage 7: sum of squares, below 2^64.
  logic [61:0]    sq6_r  [4];
  qsau_pkg::mag_t mag6_r [4];
  logic [63:0]    sum7_r;
  qsau_pkg::mag_t mag7_r [4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sq6_r[i] <= mag5_r[i] * mag5_r[i];
      end
      mag6_r <= mag5_r;
      sum7_r <= 64'(sq6_r[0]) + 64'(sq6_r[1]) + 64'(sq6_r[2]) + 64'(sq6_r[3]);
      mag7_r <= mag6_r;
    end
  end

  // Square root; the magnitudes ride alongside.
  logic [31:0] root;
  logic [3:0][qsau_pkg::MAG_W-1:0] magd_r [NSQ];

  qsau_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .val  (sum7_r),
    .root (root)
  );

  for (genvar k = 0; k < NSQ; k++) begin : g_magd
    always_ff @(posedge clk) begin
      if (en) begin
        if (k == 0) begin
          magd_r[k] <= {mag7_r[3], mag7_r[2], mag7_r[1], mag7_r[0]};
        end else begin
          magd_r[k] <= magd_r[k-1];
        end
      end
    end
  end

  // Numerator stage: mag * 2^30 + floor(n / 2), for round half up.
  logic [qsau_pkg::NUM_W-1:0] num8_r [4];
  logic [31:0]                den8_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        num8_r[i] <= {magd_r[NSQ-1][i], 30'b0} + qsau_pkg::NUM_W'(root >> 1);
      end
      den8_r <= root;
    end
  end

  logic [31:0] quo [4];

  for (genvar i = 0; i < 4; i++) begin : g_div
    qsau_div u_div (
      .clk (clk),
      .en  (en),
      .num (num8_r[i]),
      .den (den8_r),
      .quo (quo[i])
    );
  end

  // Saturate, apply sign, and force zeros on a zero-norm product.
  qsau_pkg::res_t res_new;
  logic signed [31:0] comp [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [31:0] m;
      m = quo[i][31] ? 32'h7FFF_FFFF : quo[i];
      if (side_r[TOT-1].zero) begin
        comp[i] = '0;
      end else if (side_r[TOT-1].sgn[i]) begin
        comp[i] = -$signed(m);
      end else begin
        comp[i] = $signed(m);
      end
    end
    res_new.w    = comp[0];
    res_new.x    = comp[1];
    res_new.y    = comp[2];
    res_new.z    = comp[3];
    res_new.zero = side_r[TOT-1].zero;
  end

  // Two-entry output buffer.
  qsau_pkg::res_t ent0;
  qsau_pkg::res_t ent1;
  logic push;
  logic pop;

  assign push = en && vld[TOT-1];
  assign pop  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (!push && pop) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      ent0 <= res_new;
    end else if (push) begin
      if (cnt == 2'd0) begin
        ent0 <= res_new;
      end else begin
        ent1 <= res_new;
      end
    end else if (pop) begin
      ent0 <= ent1;
    end
  end

  assign out_valid = (cnt != 2'd0);
  assign out_w     = ent0.w;
  assign out_x     = ent0.x;
  assign out_y     = ent0.y;
  assign out_z     = ent0.z;
  assign zero_norm = ent0.zero;

endmodule

`default_nettype wire

@@ rtl/core/qsau_check.sv @@
// ----------------------------------------------------------------------------
// qsau_check
// Port-level checks for the small-angle quaternion update.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quaternion_small_angle_update_macros.svh"

module qsau_check (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [31:0] out_w,
  input wire logic signed [31:0] out_x,
  input wire logic signed [31:0] out_y,
  input wire logic signed [31:0] out_z,
  input wire logic               zero_norm
);

  // A stalled result holds.
  `QSAU_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_w) && $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(zero_norm))

  // The scalar part is never negative.
  `QSAU_ASSERT_IMPLY(a_w_nonneg, clk, rst, out_valid, !out_w[31])

  // A zero-norm result is all zeros.
  `QSAU_ASSERT_IMPLY(a_zero_out, clk, rst, out_valid && zero_norm, out_w == 0 && out_x == 0 && out_y == 0 && out_z == 0)

endmodule

bind quaternion_small_angle_update qsau_check u_qsau_check (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_w     (out_w),
  .out_x     (out_x),
  .out_y     (out_y),
  .out_z     (out_z),
  .zero_norm (zero_norm)
);

`default_nettype wire

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// Testbench for the small-angle quaternion update
// Drives quaternion and rotation items through a bursty sender, stalls the
// result side on its own pattern, predicts each result in integer arithmetic
// and compares every field in order of arrival.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  typedef struct {
    logic signed [31:0] qw, qx, qy, qz, rx, ry, rz;
  } pose_item_t;

  typedef struct {
    logic signed [31:0] w, x, y, z;
    logic               zero;
  } unit_quat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
  logic signed [31:0] rot_x = '0, rot_y = '0, rot_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_w, out_x, out_y, out_z;
  logic zero_norm;

  pose_item_t pending_items[$];
  unit_quat_t expected_quats[$];
  int error_count = 0;
  bit stimulus_done = 1'b0;
  bit long_hold_done = 1'b0;

  quaternion_small_angle_update dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_w(out_w), .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .zero_norm(zero_norm)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Floor of arithmetic shift by two, applied to an exact 64-bit product.
  function automatic longint half_cross(input longint a, input longint b);
    longint prod;
    prod = a * b;
    return prod >>> 2;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Computes q * (1, r/2), block-scales, normalizes and folds to w >= 0.
  function automatic unit_quat_t predict_update(input pose_item_t it);
    longint prod[4];
    longint unsigned mag[4];
    bit neg[4];
    longint unsigned peak, sumsq, norm, m;
    longint qw, qx, qy, qz, rx, ry, rz, v;
    int blen, i;
    logic signed [31:0] res[4];
    unit_quat_t r;
    qw = it.qw; qx = it.qx; qy = it.qy; qz = it.qz;
    rx = it.rx; ry = it.ry; rz = it.rz;
    prod[0] = qw * 64'sd536870912 - half_cross(qx, rx) - half_cross(qy, ry)
              - half_cross(qz, rz);
    prod[1] = qx * 64'sd536870912 + half_cross(qw, rx) + half_cross(qy, rz)
              - half_cross(qz, ry);
    prod[2] = qy * 64'sd536870912 + half_cross(qw, ry) + half_cross(qz, rx)
              - half_cross(qx, rz);
    prod[3] = qz * 64'sd536870912 + half_cross(qw, rz) + half_cross(qx, ry)
              - half_cross(qy, rx);
    peak = 0;
    for (i = 0; i < 4; i++) begin
      neg[i] = prod[i] < 0;
      mag[i] = neg[i] ? -prod[i] : prod[i];
      if (mag[i] > peak) peak = mag[i];
    end
    if (peak == 0) begin
      r.w = '0; r.x = '0; r.y = '0; r.z = '0; r.zero = 1'b1;
      return r;
    end
    blen = 0;
    while (blen < 64 && (peak >> blen) != 0) blen++;
    sumsq = 0;
    for (i = 0; i < 4; i++) begin
      if (blen > 31) mag[i] = mag[i] >> (blen - 31);
      else mag[i] = mag[i] << (31 - blen);
      sumsq = sumsq + mag[i] * mag[i];
    end
    norm = int_sqrt(sumsq);
    if (norm == 0) norm = 1;
    for (i = 0; i < 4; i++) begin
      m = ((mag[i] << 30) + (norm >> 1)) / norm;
      if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
      v = m;
      if (neg[i] != neg[0]) v = -v;
      res[i] = v[31:0];
    end
    r.w = res[0]; r.x = res[1]; r.y = res[2]; r.z = res[3]; r.zero = 1'b0;
    return r;
  endfunction

  function automatic logic signed [31:0] pick_field(input int kind);
    case (kind)
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sd0;
      3: return 32'sh4000_0000;
      4: return $signed($urandom_range(0, 4095)) - 2048;
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic add_item(input logic signed [31:0] qw, qx, qy, qz, rx, ry, rz);
    pose_item_t it;
    it.qw = qw; it.qx = qx; it.qy = qy; it.qz = qz;
    it.rx = rx; it.ry = ry; it.rz = rz;
    pending_items.push_back(it);
  endtask

  // Stimulus. The directed part covers the extreme values, the zero rotation
  // pass-through, a zero-norm product and a negative scalar part.
  // The random part is mostly unit-ish quaternions with small rotations, the
  // realistic use, mixed with full-range noise.
  initial begin
    logic signed [31:0] one;
    int sel;
    one = 32'sh4000_0000;
    add_item(one, 0, 0, 0, 0, 0, 0);
    add_item(-one, 0, 0, 0, 0, 0, 0);
    add_item(0, 0, 0, 0, 0, 0, 0);
    add_item(0, 0, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1234_5678);
    add_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
             32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    add_item(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
             32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    add_item(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
             32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    add_item(one, 0, 0, 0, 32'sh0010_0000, 0, 0);
    add_item(one, 0, 0, 0, 0, 32'shFFF0_0000, 32'sh0008_0000);
    add_item(0, one, 0, 0, 32'sh0100_0000, 0, 0);
    add_item(0, 0, 0, 0, 0, 0, 0);
    add_item(32'sd1, 0, 0, 0, 0, 0, 0);
    add_item(-32'sd1, 32'sd1, 0, 0, 0, 0, 0);
    add_item(0, 32'sd1, 0, 0, 32'sd1, 0, 0);
    add_item(0, one, one, one, 32'sh8000_0000, 0, 0);
    add_item(-one, one, -one, one, 32'sh0000_1000, 32'sh0000_2000, 32'sh7000_0000);
    for (int n = 0; n < 1535; n++) begin
      sel = $urandom_range(0, 9);
      if (sel < 6)
        add_item($signed($urandom_range(0, 32'h7FFF_FFFF)) - 32'sh3FFF_FFFF,
                 $signed($urandom_range(0, 32'h7FFF_FFFF)) - 32'sh3FFF_FFFF,
                 $signed($urandom_range(0, 32'h7FFF_FFFF)) - 32'sh3FFF_FFFF,
                 $signed($urandom_range(0, 32'h7FFF_FFFF)) - 32'sh3FFF_FFFF,
                 $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh00FF_FFFF,
                 $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh00FF_FFFF,
                 $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh00FF_FFFF);
      else if (sel < 8)
        add_item($signed($urandom()), $signed($urandom()), $signed($urandom()),
                 $signed($urandom()), $signed($urandom()), $signed($urandom()),
                 $signed($urandom()));
      else
        add_item(pick_field($urandom_range(0, 5)), pick_field($urandom_range(0, 5)),
                 pick_field($urandom_range(0, 5)), pick_field($urandom_range(0, 5)),
                 pick_field($urandom_range(0, 5)), pick_field($urandom_range(0, 5)),
                 pick_field($urandom_range(0, 5)));
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // Sender: bursts of random length separated by random gaps. Inputs change
  // only at the falling edge; an offered item holds until it is taken.
  int burst_left = 0;
  int gap_left = 0;
  bit taken_last;

  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && taken_last) begin
        expected_quats.push_back(predict_update(pending_items.pop_front()));
      end
      if (!in_valid || taken_last) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_valid <= 1'b1;
          quat_w <= pending_items[0].qw; quat_x <= pending_items[0].qx;
          quat_y <= pending_items[0].qy; quat_z <= pending_items[0].qz;
          rot_x <= pending_items[0].rx; rot_y <= pending_items[0].ry;
          rot_z <= pending_items[0].rz;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end
        end else begin
          in_valid <= 1'b0;
          stimulus_done <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    taken_last <= in_valid && !in_stall && !rst;
  end

  // Receiver: a stall pattern of its own, plus one long hold-off once a few
  // hundred items have gone in, so that the pipeline backs up to the input.
  int stall_mode = 0;
  int stall_left = 0;
  int hold_count = 0;

  always @(negedge clk) begin
    if (!rst) begin
      if (!long_hold_done && pending_items.size() < 1200) begin
        out_stall <= 1'b1;
        hold_count <= hold_count + 1;
        if (hold_count == 300) long_hold_done <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ~out_stall;
          default: out_stall <= ($urandom_range(0, 1) == 0);
        endcase
      end else begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(10, 120);
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: compares each result taken at a rising edge with the oldest
  // prediction, field by field.
  always @(posedge clk) begin
    unit_quat_t exp_q;
    if (!rst && out_valid && !out_stall) begin
      if (expected_quats.size() == 0) begin
        $error("result with no prediction pending");
        error_count++;
      end else begin
        exp_q = expected_quats.pop_front();
        if (out_w !== exp_q.w) begin
          $error("out_w expected %0d actual %0d", exp_q.w, out_w); error_count++;
        end
        if (out_x !== exp_q.x) begin
          $error("out_x expected %0d actual %0d", exp_q.x, out_x); error_count++;
        end
        if (out_y !== exp_q.y) begin
          $error("out_y expected %0d actual %0d", exp_q.y, out_y); error_count++;
        end
        if (out_z !== exp_q.z) begin
          $error("out_z expected %0d actual %0d", exp_q.z, out_z); error_count++;
        end
        if (zero_norm !== exp_q.zero) begin
          $error("zero_norm expected %0d actual %0d", exp_q.zero, zero_norm);
          error_count++;
        end
      end
    end
  end

  // End of run: drain the predictions, then let the pipeline latency pass so
  // that any stray result would still show up.
  initial begin
    wait (stimulus_done);
    wait (expected_quats.size() == 0);
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
